@@ rtl/lubr_pkg.sv @@
// shared types and constants for the longest unique byte run block
package lubr_pkg;

    localparam int CHAR_W            = 8;
    localparam int CHAR_COUNT        = 256;
    localparam int LEN_W             = 17;
    localparam int POSITION_BITS_DEF = 16;

    localparam logic [LEN_W-1:0] LEN_FIELD_MAX = '1;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [LEN_W-1:0]  t_len;

endpackage

@@ rtl/lubr_ram.sv @@
// generic single write port ram with registered read
module lubr_ram
    import lubr_pkg::*;
#(
    parameter int WIDTH = POSITION_BITS_DEF,
    parameter int DEPTH = CHAR_COUNT
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/longest_unique_byte_run_top.sv @@
// longest duplicate-free byte run per string, one byte per cycle unless the output stalls
// each byte is registered in stage 1 and its result in the output register; stage 1 holds while the output is full
// the byte rate is set by one position ram read and one write per byte
// a repeat of the last written byte is served from a forwarding register
// reset: synchronous active low, clears control, seen flags and string state
// the position ram is not cleared; entries are used only after being written, as marked by the seen flags
module longest_unique_byte_run_top
    import lubr_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [CHAR_W-1:0] i_char_byte,
    input  logic             i_start_string,
    input  logic             i_end_string,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [LEN_W-1:0] o_window_length,
    output logic [LEN_W-1:0] o_longest_length,
    output logic             o_final_result,
    output logic             o_overflow
);

    localparam int PB = POSITION_BITS;
    localparam int WW = (PB + 1 > LEN_W) ? PB + 1 : LEN_W;
    localparam logic [WW-1:0] POS_LIMIT = WW'(1) << PB;
    localparam logic [WW-1:0] LEN_CAP   = (PB >= LEN_W) ? WW'(LEN_FIELD_MAX) : POS_LIMIT;

    // stage 1 item
    logic          r_s1_vld;
    t_char         r_s1_char;
    logic          r_s1_start;
    logic          r_s1_end;

    // string state
    logic [PB:0]         r_pos, n_pos;
    logic [PB-1:0]       r_ws, n_ws;
    t_len                r_best, n_best;
    logic                r_ovf, n_ovf;
    logic [CHAR_COUNT-1:0] r_seen, n_seen;

    // last write, for forwarding
    logic          r_wr_vld;
    t_char         r_wr_char;
    logic [PB-1:0] r_wr_pos;

    // output register
    logic          r_out_vld;
    t_len          r_out_win;
    t_len          r_out_long;
    logic          r_out_fin;
    logic          r_out_ovf;

    logic          in_xfer;
    logic          s1_adv;
    logic          out_free;
    logic [PB-1:0] ram_rdata;
    logic [PB-1:0] last_pos;
    logic [PB:0]   pos_eff;
    logic [PB-1:0] ws_eff;
    t_len          best_eff;
    logic          ovf_now;
    logic          seen_eff;
    logic          hit;
    logic [WW-1:0] win;
    logic [WW-1:0] win_cap;
    t_len          n_win;

    assign out_free = !r_out_vld || i_ready;
    assign s1_adv   = r_s1_vld && out_free;
    assign o_ready  = !r_s1_vld || s1_adv;
    assign in_xfer  = i_valid && o_ready;

    lubr_ram #(
        .WIDTH (PB),
        .DEPTH (CHAR_COUNT)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv && !ovf_now),
        .i_waddr (r_s1_char),
        .i_wdata (pos_eff[PB-1:0]),
        .i_re    (in_xfer),
        .i_raddr (i_char_byte),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        pos_eff  = r_s1_start ? '0 : r_pos;
        ws_eff   = r_s1_start ? '0 : r_ws;
        best_eff = r_s1_start ? '0 : r_best;
        ovf_now  = (!r_s1_start && r_ovf) || pos_eff[PB];
        last_pos = (r_wr_vld && r_wr_char == r_s1_char) ? r_wr_pos : ram_rdata;
        seen_eff = !r_s1_start && r_seen[r_s1_char];
        hit      = seen_eff && (last_pos >= ws_eff);
        n_ws     = hit ? PB'({1'b0, last_pos} + (PB+1)'(1)) : ws_eff;
        win      = WW'(pos_eff) - WW'(n_ws) + WW'(1);
        win_cap  = (win > LEN_CAP) ? LEN_CAP : win;
        n_seen   = r_s1_start ? '0 : r_seen;
        if (ovf_now) begin
            n_win  = LEN_W'(LEN_CAP);
            n_best = LEN_W'(LEN_CAP);
            n_pos  = pos_eff;
            n_ovf  = 1'b1;
        end else begin
            n_win  = LEN_W'(win_cap);
            n_best = (win_cap > WW'(best_eff)) ? LEN_W'(win_cap) : best_eff;
            n_pos  = pos_eff + (PB+1)'(1);
            n_ovf  = 1'b0;
            n_seen[r_s1_char] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_wr_vld  <= 1'b0;
            r_pos     <= '0;
            r_ws      <= '0;
            r_best    <= '0;
            r_ovf     <= 1'b0;
            r_seen    <= '0;
        end else begin
            if (o_ready) begin
                r_s1_vld <= i_valid;
            end
            if (out_free) begin
                r_out_vld <= r_s1_vld;
            end
            if (s1_adv) begin
                r_pos  <= n_pos;
                r_ws   <= ovf_now ? ws_eff : n_ws;
                r_best <= n_best;
                r_ovf  <= n_ovf;
                r_seen <= n_seen;
                if (!ovf_now) begin
                    r_wr_vld <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_char  <= i_char_byte;
            r_s1_start <= i_start_string;
            r_s1_end   <= i_end_string;
        end
        if (s1_adv && !ovf_now) begin
            r_wr_char <= r_s1_char;
            r_wr_pos  <= pos_eff[PB-1:0];
        end
        if (s1_adv) begin
            r_out_win  <= n_win;
            r_out_long <= n_best;
            r_out_fin  <= r_s1_end;
            r_out_ovf  <= ovf_now;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_window_length  = r_out_win;
    assign o_longest_length = r_out_long;
    assign o_final_result   = r_out_fin;
    assign o_overflow       = r_out_ovf;

`ifndef SYNTHESIS
    a_ovf_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |->
            (o_window_length == LEN_W'(LEN_CAP) && o_longest_length == LEN_W'(LEN_CAP)))
        else $error("overflow result not saturated");

    a_win_le_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_window_length != '0 && o_window_length <= o_longest_length))
        else $error("window length exceeds longest length");

    a_ws_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ovf |-> ({1'b0, r_ws} <= r_pos))
        else $error("window start beyond byte position");

    a_ovf_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_pos[PB])
        else $error("overflow without full position count");
`endif

endmodule

@@ verif/longest_unique_byte_run_top_tb.sv @@
// testbench for longest_unique_byte_run_top: directed and random byte strings checked against a built-in run tracker
`timescale 1ns / 1ps

module longest_unique_byte_run_top_tb;
    import lubr_pkg::*;

    localparam int              POS_BITS  = POSITION_BITS_DEF;
    localparam longint unsigned POS_COUNT = 64'd1 << POS_BITS;
    localparam longint unsigned LEN_CAP   =
        (POS_COUNT < longint'(LEN_FIELD_MAX)) ? POS_COUNT : longint'(LEN_FIELD_MAX);
    localparam int              RAND_ITEMS = 1300;
    localparam int              CALM_TAIL  = 200;

    typedef struct packed {
        t_char ch;
        logic  start;
        logic  fin;
        logic  hold;
    } t_byte_item;

    typedef struct packed {
        t_len win;
        t_len best;
        logic fin;
        logic ovf;
    } t_run_result;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    t_char      i_char_byte    = '0;
    logic       i_start_string = 1'b0;
    logic       i_end_string   = 1'b0;
    logic       i_ready        = 1'b0;
    logic       o_ready;
    logic       o_valid;
    t_len       o_window_length;
    t_len       o_longest_length;
    logic       o_final_result;
    logic       o_overflow;

    t_byte_item  pending[$];
    t_run_result run_q[$];

    // run tracker state
    longint unsigned last_pos[CHAR_COUNT];
    bit              seen[CHAR_COUNT];
    longint unsigned win_start;
    longint unsigned str_pos;
    longint unsigned best_len;
    bit              ovf_seen;

    int   sent_cnt  = 0;
    int   n_recv    = 0;
    int   n_bad     = 0;
    int   n_rand    = 0;
    logic calm      = 1'b0;
    int   send_gap  = 0;
    int   send_pct  = 20;
    int   recv_gap  = 0;
    int   recv_pct  = 20;

    always #6 i_clk = ~i_clk;

    longest_unique_byte_run_top #(
        .POSITION_BITS(POS_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_char_byte     (i_char_byte),
        .i_start_string  (i_start_string),
        .i_end_string    (i_end_string),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_window_length (o_window_length),
        .o_longest_length(o_longest_length),
        .o_final_result  (o_final_result),
        .o_overflow      (o_overflow)
    );

    function automatic t_run_result track_byte(input t_byte_item it);
        t_run_result     r;
        longint unsigned w;
        if (it.start) begin
            foreach (seen[k]) seen[k] = 1'b0;
            win_start = 0;
            str_pos   = 0;
            best_len  = 0;
            ovf_seen  = 1'b0;
        end
        if (!ovf_seen && str_pos >= POS_COUNT) ovf_seen = 1'b1;
        r.fin = it.fin;
        if (ovf_seen) begin
            best_len = LEN_CAP;
            r.win    = t_len'(LEN_CAP);
            r.best   = t_len'(LEN_CAP);
            r.ovf    = 1'b1;
            return r;
        end
        if (seen[it.ch] && last_pos[it.ch] >= win_start) win_start = last_pos[it.ch] + 1;
        last_pos[it.ch] = str_pos;
        seen[it.ch]     = 1'b1;
        w = str_pos - win_start + 1;
        if (w > LEN_CAP) w = LEN_CAP;
        if (w > best_len) best_len = w;
        str_pos++;
        r.win  = t_len'(w);
        r.best = t_len'(best_len);
        r.ovf  = 1'b0;
        return r;
    endfunction

    task automatic add_byte(input t_char ch, input logic st, input logic fin,
                            input logic hold = 1'b0);
        t_byte_item it;
        it.ch    = ch;
        it.start = st;
        it.fin   = fin;
        it.hold  = hold;
        pending.push_back(it);
    endtask

    task automatic add_string(input int len, input int alpha, input logic hold);
        t_char base;
        logic  with_start;
        logic  with_end;
        base       = t_char'($urandom);
        with_start = ($urandom_range(99) >= 10);
        with_end   = ($urandom_range(99) >= 10);
        for (int k = 0; k < len; k++) begin
            add_byte(t_char'(base + $urandom_range(alpha - 1)),
                     (k == 0 && with_start) || ($urandom_range(199) == 0),
                     (k == len - 1 && with_end) || ($urandom_range(49) == 0),
                     hold && k == 0);
        end
        n_rand += len;
    endtask

    // full 256-byte permutation so the window reaches every byte value
    task automatic add_unique_string();
        t_char perm[CHAR_COUNT];
        t_char tmp;
        int    j;
        int    extra;
        foreach (perm[k]) perm[k] = t_char'(k);
        for (int k = CHAR_COUNT - 1; k > 0; k--) begin
            j       = $urandom_range(k);
            tmp     = perm[k];
            perm[k] = perm[j];
            perm[j] = tmp;
        end
        extra = $urandom_range(20, 1);
        foreach (perm[k]) add_byte(perm[k], k == 0, 1'b0);
        for (int k = 0; k < extra; k++) add_byte(t_char'($urandom), 1'b0, k == extra - 1);
        n_rand += CHAR_COUNT + extra;
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            n_bad++;
            if (n_bad <= 10) begin
                $display("mismatch on result %0d: %s expected %0d got %0d",
                         n_recv, name, want, got);
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_byte_item nxt;
        logic       nxt_valid;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nxt_valid = i_valid;
            if (i_valid && o_ready) begin
                nxt.ch    = i_char_byte;
                nxt.start = i_start_string;
                nxt.fin   = i_end_string;
                nxt.hold  = 1'b0;
                run_q.push_back(track_byte(nxt));
                sent_cnt++;
                nxt_valid = 1'b0;
                if (sent_cnt % 64 == 0) begin
                    case ($urandom_range(3))
                        0: send_pct = 0;
                        1: send_pct = 10;
                        2: send_pct = 30;
                        default: send_pct = 60;
                    endcase
                end
            end
            if (!nxt_valid && pending.size() > 0) begin
                if (send_gap == 0 && pending.size() >= CALM_TAIL
                        && $urandom_range(99) < send_pct) begin
                    send_gap = $urandom_range(6, 1);
                end
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending[0].hold && n_recv != sent_cnt) begin
                    // drain all outstanding results first
                end else begin
                    nxt             = pending.pop_front();
                    i_char_byte    <= nxt.ch;
                    i_start_string <= nxt.start;
                    i_end_string   <= nxt.fin;
                    nxt_valid       = 1'b1;
                end
            end
            i_valid <= nxt_valid;
            calm    <= (pending.size() < CALM_TAIL);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_run_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (run_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) $display("result %0d arrived with none expected", n_recv);
                end else begin
                    want = run_q.pop_front();
                    check_field("window_length", want.win, o_window_length);
                    check_field("longest_length", want.best, o_longest_length);
                    check_field("final_result", want.fin, o_final_result);
                    check_field("overflow", want.ovf, o_overflow);
                end
                n_recv <= n_recv + 1;
                if (n_recv % 50 == 0) recv_pct = 10 * $urandom_range(5);
            end
            if (recv_gap == 0 && !calm && $urandom_range(99) < recv_pct) begin
                recv_gap = $urandom_range(6, 1);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        int    pick;

        // strings without a start after reset, and continuing after an end
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b1);
        add_byte(8'h01, 1'b0, 1'b0);
        add_byte(8'h01, 1'b0, 1'b0);
        // start clears the seen flags
        add_byte(8'h80, 1'b1, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h40, 1'b0, 1'b0);
        add_byte(8'h40, 1'b0, 1'b0);
        // repeat seen before the window start
        add_byte(8'h80, 1'b0, 1'b1);
        add_byte(8'h7F, 1'b1, 1'b1);
        add_byte(8'h55, 1'b1, 1'b0, 1'b1);
        add_byte(8'hAA, 1'b0, 1'b0);
        add_byte(8'h55, 1'b0, 1'b1);
        add_byte(8'h01, 1'b1, 1'b0);
        add_byte(8'h02, 1'b0, 1'b0);
        add_byte(8'h04, 1'b0, 1'b0);
        add_byte(8'h08, 1'b0, 1'b0);
        add_byte(8'h10, 1'b0, 1'b0);
        add_byte(8'h20, 1'b0, 1'b0);
        add_byte(8'h02, 1'b0, 1'b1);

        while (n_rand < RAND_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                add_unique_string();
            end else if (pick < 12) begin
                add_string($urandom_range(300, 61), 256, $urandom_range(29) == 0);
            end else if (pick < 35) begin
                add_string($urandom_range(60, 13), 1 << $urandom_range(8, 1),
                           $urandom_range(29) == 0);
            end else begin
                add_string($urandom_range(12, 1), 1 << $urandom_range(8, 1),
                           $urandom_range(29) == 0);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        forever begin
            @(posedge i_clk);
            if (pending.size() == 0 && !i_valid && n_recv == sent_cnt) break;
        end
        repeat (10) @(posedge i_clk);
        if (n_bad == 0 && run_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ longest_unique_byte_run_top.f @@
rtl/lubr_pkg.sv
rtl/lubr_ram.sv
rtl/longest_unique_byte_run_top.sv
verif/longest_unique_byte_run_top_tb.sv
